// File: rtl/ols_pkg.sv
`default_nettype none

package ols_pkg;

    localparam int DATA_W = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_INSERT     = 3'd4;
    localparam logic [2:0] CMD_SEARCH     = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] value;
        logic [6:0]               position;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] found_index;
        logic [6:0] entry_count;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/ols_mem.sv
`default_nettype none

module ols_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [ols_pkg::DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [ols_pkg::DATA_W-1:0] rdata
);
    import ols_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/ols_ctrl.sv
`default_nettype none

module ols_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire ols_pkg::in_item_t          s_item,
    input  wire logic                       out_free,
    output logic                            res_valid,
    output ols_pkg::out_item_t              res_item,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output logic [ols_pkg::DATA_W-1:0]      mem_wdata,
    output logic [AW-1:0]                   mem_raddr,
    input  wire logic [ols_pkg::DATA_W-1:0] mem_rdata
);
    import ols_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_PLACE = 4'b0100,
        S_SCAN  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] value_reg, value_next;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] last_idx;
    logic [AW-1:0] head_dec;
    logic [2:0]    res_status;
    logic [AW-1:0] res_idx;

    // physical slot of a logical index in the ring
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign last_idx = AW'(count_reg - CW'(1));
    assign head_dec = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        value_next = value_reg;
        mem_we     = 1'b0;
        mem_waddr  = wrap_add(head_reg, AW'(count_reg));
        mem_wdata  = s_item.value;
        mem_raddr  = head_reg;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_idx    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_valid = 1'b1;
                    case (s_item.cmd)
                        CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                res_status = ST_FULL;
                            end else begin
                                head_next  = head_dec;
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (is_full) begin
                                res_status = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty) begin
                                res_status = ST_EMPTY;
                            end else begin
                                head_next  = wrap_add(head_reg, AW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (is_empty) begin
                                res_status = ST_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_INSERT: begin
                            if (32'(s_item.position) > 32'(count_reg)) begin
                                res_status = ST_INVALID;
                            end else if (is_full) begin
                                res_status = ST_FULL;
                            end else if (32'(s_item.position) == 32'(count_reg)) begin
                                // insert at the end is an append
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end else begin
                                res_valid  = 1'b0;
                                mem_raddr  = wrap_add(head_reg, last_idx);
                                idx_next   = last_idx;
                                pos_next   = AW'(s_item.position);
                                value_next = s_item.value;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_SEARCH: begin
                            if (is_empty) begin
                                res_status = ST_NOTFOUND;
                            end else begin
                                res_valid  = 1'b0;
                                idx_next   = '0;
                                value_next = s_item.value;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            res_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // entry idx arrives now, moves one slot toward the back
                mem_we    = 1'b1;
                mem_waddr = wrap_add(head_reg, idx_reg + AW'(1));
                mem_wdata = mem_rdata;
                if (idx_reg == pos_reg) begin
                    state_next = S_PLACE;
                end else begin
                    mem_raddr = wrap_add(head_reg, idx_reg - AW'(1));
                    idx_next  = idx_reg - AW'(1);
                end
            end
            S_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = wrap_add(head_reg, pos_reg);
                mem_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                res_valid  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN: begin
                if (mem_rdata == value_reg) begin
                    res_valid  = 1'b1;
                    res_idx    = idx_reg;
                    state_next = S_IDLE;
                end else if (idx_reg == last_idx) begin
                    res_valid  = 1'b1;
                    res_status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end else begin
                    mem_raddr = wrap_add(head_reg, idx_reg + AW'(1));
                    idx_next  = idx_reg + AW'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_item.status      = res_status;
    assign res_item.found_index = 6'(res_idx);
    assign res_item.entry_count = 7'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        value_reg <= value_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> (idx_reg >= pos_reg) && (32'(idx_reg) < 32'(count_reg)))
        else $error("shift index out of range");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> 32'(idx_reg) < 32'(count_reg))
        else $error("search index beyond stored entries");

    a_place_after_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PLACE |-> $past(state_reg) == S_SHIFT)
        else $error("place step without shift");
`endif

endmodule

`default_nettype wire

// File: rtl/ordered_list_store.sv
// ordered_list_store: an ordered list of up to CAPACITY signed 32-bit values
// held as a ring in one synchronous memory, with a head pointer and a count.
// input channel s_valid/s_ready/s_item carries one command per item: push
// front or back, pop front or back, insert at a position, or search for a key.
// result channel m_valid/m_ready/m_item returns exactly one item per command
// with status, found index and the entry count after the command.
// pushes, pops and rejected commands finish in the accept cycle; the result
// sits in the output register from the next cycle on, so these run one item
// per cycle while the receiver keeps up.
// insert at position p below the entry count n moves entries n - 1 down to p
// one slot back, one entry per cycle through the memory read/write ports,
// then writes the new value at p; insert at p equal to n is an append and
// finishes like a push. search compares one stored entry per cycle from the
// front and stops at the first match or after the last entry, a miss.
// a new item is taken only when the controller is idle and the output
// register is empty or being drained; a stalled receiver holds the result
// and back-pressures the input channel.
// synchronous reset (aresetn low) empties the list; memory contents need
// no clearing since only entries below the count are ever read.
`default_nettype none

module ordered_list_store #(
    parameter int CAPACITY = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ols_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ols_pkg::out_item_t      m_item
);
    import ols_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic              out_free;
    logic              res_valid;
    out_item_t         res_item;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic      m_valid_reg;
    out_item_t m_item_reg;

    assign out_free = !m_valid_reg || m_ready;

    ols_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ols_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_item  (res_item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // output register decouples the result from the controller
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_valid_reg || m_ready))
        else $error("result item would overwrite an undelivered item");
`endif

endmodule

`default_nettype wire
